FILE: rtl/ntps_pkg.sv
// ----------------------------------------------------------------------------
// ntps_pkg: shared types and constants for the neighbor table
// Entry layout, transaction payloads, status and register codes, FSM states.
// ----------------------------------------------------------------------------
package ntps_pkg;

   // table geometry
   localparam int TABLE_ENTRIES_DEF = 10;

   // fixed card acceptance rules
   localparam logic [7:0] CHAN_LOW     = 8'd11;
   localparam logic [7:0] CHAN_HIGH    = 8'd27;
   localparam logic [7:0] CARD_PAYLOAD = 8'd3;

   // configuration reset values
   localparam logic signed [7:0] MIN_RSSI_RST        = -8'sd90;
   localparam logic [7:0]        TIME_TO_LIVE_RST    = 8'd10;
   localparam logic [15:0]       AGE_PERIOD_RST      = 16'd60;
   localparam logic [15:0]       RESELECT_PERIOD_RST = 16'd60;
   localparam logic [7:0]        ETX_LIMIT_RST       = 8'd250;
   localparam logic [7:0]        SLOT_LOW_RST        = 8'd2;
   localparam logic [7:0]        SLOT_HIGH_RST       = 8'd49;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_RSSI        = 3'd0,
      REG_TIME_TO_LIVE    = 3'd1,
      REG_AGE_PERIOD      = 3'd2,
      REG_RESELECT_PERIOD = 3'd3,
      REG_ETX_LIMIT       = 3'd4,
      REG_SLOT_LOW        = 3'd5,
      REG_SLOT_HIGH       = 3'd6
   } reg_index_type;

   typedef enum logic {
      CMD_CARD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_STORED    = 3'd0,
      STAT_BAD_LEN   = 3'd1,
      STAT_WEAK_RSSI = 3'd2,
      STAT_INVALID   = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_TICK_DONE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECIDE = 2'd1,
      ST_SCAN   = 2'd2,
      ST_LAST   = 2'd3
   } state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [15:0]        sender_addr;
      logic signed [7:0]  rssi;
      logic [7:0]         link_quality;
      logic [7:0]         adv_slot;
      logic [7:0]         adv_channel;
      logic [7:0]         adv_etx;
      logic [7:0]         payload_len;
      logic [31:0]        now_seconds;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        parent_valid;
      logic [15:0] parent_addr;
      logic [7:0]  parent_slot;
      logic [7:0]  parent_channel;
      logic [7:0]  own_etx;
      logic        parent_changed;
   } rsp_type;

   // one neighbor table entry
   typedef struct packed {
      logic              valid;
      logic [15:0]       addr;
      logic [7:0]        ttl;
      logic signed [7:0] rssi;
      logic [7:0]        link_quality;
      logic [7:0]        slot;
      logic [7:0]        channel;
      logic [7:0]        etx;
   } entry_type;

   // per-cell control
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

FILE: rtl/ntps_cell.sv
// ----------------------------------------------------------------------------
// ntps_cell: one neighbor table entry in the rotating chain
// Takes its neighbor's entry on shift, or a new entry on load.
// ----------------------------------------------------------------------------
module ntps_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  ntps_pkg::cell_ctl_type ctl,
   input  ntps_pkg::entry_type  shift_in,
   input  ntps_pkg::entry_type  load_in,
   output ntps_pkg::entry_type  entry_out
);

   logic                valid_ff;
   ntps_pkg::entry_type data_ff;

   // valid mark clears at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= load_in.valid;
      end else if (ctl.shift) begin
         valid_ff <= shift_in.valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= load_in;
      end else if (ctl.shift) begin
         data_ff <= shift_in;
      end
   end

   always_comb begin
      entry_out       = data_ff;
      entry_out.valid = valid_ff;
   end

endmodule

FILE: rtl/neighbor_table_parent_select.sv
// ----------------------------------------------------------------------------
// neighbor_table_parent_select: neighbor table with ETX parent selection
// Stores neighbor cards in a rotating chain of entry cells, ages entries on
// time ticks and picks the lowest-ETX neighbor as parent.
// ----------------------------------------------------------------------------
//
//  channel | ports                            | direction | moves
//  --------+----------------------------------+-----------+---------------------
//  request | req_valid, req_stall, req_data   | in        | card or tick
//  result  | rsp_valid, rsp_stall, rsp_data   | out       | status and parent
//  csr     | csr_write, csr_index, csr_wdata  | in        | register write
//
//  Each transaction passes through capture, a check step, a rotation of the
//  chain once past the head cell, and a commit step. A card with bad fields
//  skips the rotation. The single rotating read point at the head of the
//  chain makes the scan visit the entries one at a time.
//  Reset clears all valid marks at once; no clearing pass follows.
//  A new request is taken while an earlier result still waits in the output
//  register; the commit step holds while that register is full and stalled.
// ----------------------------------------------------------------------------
module neighbor_table_parent_select #(
   parameter int TABLE_ENTRIES = ntps_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ntps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ntps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [ntps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ntps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // configuration registers
   logic signed [7:0] min_rssi_ff;
   logic [7:0]        ttl_cfg_ff;
   logic [15:0]       age_period_ff;
   logic [15:0]       resel_period_ff;
   logic [7:0]        etx_limit_ff;
   logic [7:0]        slot_low_ff;
   logic [7:0]        slot_high_ff;

   // control
   ntps_pkg::state_type state_ff, state_in;
   ntps_pkg::req_type   req_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                due_ff;
   logic                bad_ff;
   ntps_pkg::status_type status_ff;

   // scan trackers
   logic              match_found_ff;
   logic [IDX_W-1:0]  match_idx_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic              best_found_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [7:0]        best_etx_ff;
   logic signed [7:0] best_rssi_ff;
   logic [15:0]       best_addr_ff;
   logic [7:0]        best_slot_ff;
   logic [7:0]        best_chan_ff;
   logic              par_ok_ff;

   // parent state and its shadow copy of the entry
   logic              parent_held_ff, parent_held_in;
   logic [IDX_W-1:0]  parent_idx_ff, parent_idx_in;
   logic [15:0]       par_addr_ff, par_addr_in;
   logic [7:0]        par_slot_ff, par_slot_in;
   logic [7:0]        par_chan_ff, par_chan_in;
   logic [7:0]        own_cost_ff, own_cost_in;
   logic [31:0]       last_resel_ff, last_resel_in;
   logic [31:0]       last_age_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   ntps_pkg::rsp_type rsp_ff, rsp_in;

   // chain
   ntps_pkg::entry_type    cell_q [TABLE_ENTRIES];
   ntps_pkg::cell_ctl_type cell_ctl [TABLE_ENTRIES];
   ntps_pkg::entry_type    head, aged, tail_feed, new_entry;

   logic                 accept, rsp_free, finish, is_tick, better;
   logic                 age_due, held_keep, elapsed, do_select, store_ok, changed;
   logic [IDX_W-1:0]     target;
   ntps_pkg::status_type check_status, fin_status;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == ntps_pkg::ST_LAST) && rsp_free;
   assign is_tick  = (req_ff.cmd == ntps_pkg::CMD_TICK);

   // --------------------------------------------------------------------
   // Configuration writes
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_rssi_ff     <= ntps_pkg::MIN_RSSI_RST;
         ttl_cfg_ff      <= ntps_pkg::TIME_TO_LIVE_RST;
         age_period_ff   <= ntps_pkg::AGE_PERIOD_RST;
         resel_period_ff <= ntps_pkg::RESELECT_PERIOD_RST;
         etx_limit_ff    <= ntps_pkg::ETX_LIMIT_RST;
         slot_low_ff     <= ntps_pkg::SLOT_LOW_RST;
         slot_high_ff    <= ntps_pkg::SLOT_HIGH_RST;
      end else if (csr_write) begin
         case (csr_index)
            ntps_pkg::REG_MIN_RSSI:        min_rssi_ff     <= $signed(csr_wdata[7:0]);
            ntps_pkg::REG_TIME_TO_LIVE:    ttl_cfg_ff      <= csr_wdata[7:0];
            ntps_pkg::REG_AGE_PERIOD:      age_period_ff   <= csr_wdata;
            ntps_pkg::REG_RESELECT_PERIOD: resel_period_ff <= csr_wdata;
            ntps_pkg::REG_ETX_LIMIT:       etx_limit_ff    <= csr_wdata[7:0];
            ntps_pkg::REG_SLOT_LOW:        slot_low_ff     <= csr_wdata[7:0];
            ntps_pkg::REG_SLOT_HIGH:       slot_high_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------
   // Card checks: length, then signal strength, then field ranges
   // --------------------------------------------------------------------
   always_comb begin
      if (req_ff.payload_len != ntps_pkg::CARD_PAYLOAD) begin
         check_status = ntps_pkg::STAT_BAD_LEN;
      end else if ($signed(req_ff.rssi) < $signed(min_rssi_ff)) begin
         check_status = ntps_pkg::STAT_WEAK_RSSI;
      end else if ((req_ff.adv_slot < slot_low_ff) || (req_ff.adv_slot > slot_high_ff) ||
                   (req_ff.adv_channel < ntps_pkg::CHAN_LOW) ||
                   (req_ff.adv_channel > ntps_pkg::CHAN_HIGH) ||
                   (req_ff.adv_etx >= etx_limit_ff)) begin
         check_status = ntps_pkg::STAT_INVALID;
      end else begin
         check_status = ntps_pkg::STAT_STORED;
      end
   end

   // aging is due once the period has passed, with wrapping time
   assign age_due = (req_ff.now_seconds - last_age_ff) >= {16'd0, age_period_ff};

   // --------------------------------------------------------------------
   // Head cell: aging and best-parent compare on the entry passing by
   // --------------------------------------------------------------------
   assign head = cell_q[0];

   always_comb begin
      aged = head;
      if (is_tick && due_ff && head.valid) begin
         aged.ttl   = (head.ttl == 8'd0) ? 8'd0 : head.ttl - 8'd1;
         aged.valid = (head.ttl > 8'd1);
      end
      tail_feed = is_tick ? aged : head;
      better = aged.valid &&
               (!best_found_ff || (aged.etx < best_etx_ff) ||
                ((aged.etx == best_etx_ff) && ($signed(aged.rssi) > $signed(best_rssi_ff))));
   end

   // --------------------------------------------------------------------
   // Commit step: store the card or resolve the parent
   // --------------------------------------------------------------------
   always_comb begin
      target   = match_found_ff ? match_idx_ff : free_idx_ff;
      store_ok = !bad_ff && (match_found_ff || free_found_ff);

      new_entry.valid        = 1'b1;
      new_entry.addr         = req_ff.sender_addr;
      new_entry.ttl          = ttl_cfg_ff;
      new_entry.rssi         = req_ff.rssi;
      new_entry.link_quality = req_ff.link_quality;
      new_entry.slot         = req_ff.adv_slot;
      new_entry.channel      = req_ff.adv_channel;
      new_entry.etx          = req_ff.adv_etx;

      parent_held_in = parent_held_ff;
      parent_idx_in  = parent_idx_ff;
      par_addr_in    = par_addr_ff;
      par_slot_in    = par_slot_ff;
      par_chan_in    = par_chan_ff;
      own_cost_in    = own_cost_ff;
      last_resel_in  = last_resel_ff;
      changed        = 1'b0;

      held_keep = parent_held_ff && par_ok_ff;
      elapsed   = (req_ff.now_seconds - last_resel_ff) >= {16'd0, resel_period_ff};
      do_select = !held_keep || elapsed;

      if (is_tick) begin
         fin_status     = ntps_pkg::STAT_TICK_DONE;
         parent_held_in = held_keep;
         if (held_keep && elapsed) begin
            last_resel_in = req_ff.now_seconds;
         end
         if (do_select && best_found_ff) begin
            last_resel_in  = req_ff.now_seconds;
            own_cost_in    = best_etx_ff + 8'd1;
            changed        = !(held_keep && (parent_idx_ff == best_idx_ff));
            parent_held_in = 1'b1;
            parent_idx_in  = best_idx_ff;
            par_addr_in    = best_addr_ff;
            par_slot_in    = best_slot_ff;
            par_chan_in    = best_chan_ff;
         end
      end else if (bad_ff) begin
         fin_status = status_ff;
      end else if (store_ok) begin
         fin_status = ntps_pkg::STAT_STORED;
         // keep the parent shadow in step with its entry
         if (parent_held_ff && (parent_idx_ff == target)) begin
            par_addr_in = req_ff.sender_addr;
            par_slot_in = req_ff.adv_slot;
            par_chan_in = req_ff.adv_channel;
         end
      end else begin
         fin_status = ntps_pkg::STAT_FULL;
      end

      rsp_in.status         = fin_status;
      rsp_in.parent_valid   = parent_held_in;
      rsp_in.parent_addr    = parent_held_in ? par_addr_in : 16'd0;
      rsp_in.parent_slot    = parent_held_in ? par_slot_in : 8'd0;
      rsp_in.parent_channel = parent_held_in ? par_chan_in : 8'd0;
      rsp_in.own_etx        = own_cost_in;
      rsp_in.parent_changed = changed;
   end

   // --------------------------------------------------------------------
   // FSM: next state
   // --------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ntps_pkg::ST_IDLE: begin
            if (req_valid) state_in = ntps_pkg::ST_DECIDE;
         end
         ntps_pkg::ST_DECIDE: begin
            if (!is_tick && (check_status != ntps_pkg::STAT_STORED)) begin
               state_in = ntps_pkg::ST_LAST;
            end else begin
               state_in = ntps_pkg::ST_SCAN;
            end
         end
         ntps_pkg::ST_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = ntps_pkg::ST_LAST;
         end
         ntps_pkg::ST_LAST: begin
            if (rsp_free) state_in = ntps_pkg::ST_IDLE;
         end
         default: state_in = ntps_pkg::ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------
   // FSM: outputs
   // --------------------------------------------------------------------
   always_comb begin
      req_stall    = (state_ff != ntps_pkg::ST_IDLE);
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // --------------------------------------------------------------------
   // Per-item datapath
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
      case (state_ff)
         ntps_pkg::ST_DECIDE: begin
            idx_ff         <= '0;
            due_ff         <= age_due;
            bad_ff         <= !is_tick && (check_status != ntps_pkg::STAT_STORED);
            status_ff      <= check_status;
            match_found_ff <= 1'b0;
            free_found_ff  <= 1'b0;
            best_found_ff  <= 1'b0;
            par_ok_ff      <= 1'b0;
         end
         ntps_pkg::ST_SCAN: begin
            idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
            if (is_tick) begin
               if (better) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= idx_ff;
                  best_etx_ff   <= aged.etx;
                  best_rssi_ff  <= aged.rssi;
                  best_addr_ff  <= aged.addr;
                  best_slot_ff  <= aged.slot;
                  best_chan_ff  <= aged.channel;
               end
               if (idx_ff == parent_idx_ff) par_ok_ff <= aged.valid;
            end else begin
               if (head.valid && (head.addr == req_ff.sender_addr) && !match_found_ff) begin
                  match_found_ff <= 1'b1;
                  match_idx_ff   <= idx_ff;
               end
               if (!head.valid && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= idx_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // parent and timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         parent_held_ff <= 1'b0;
         parent_idx_ff  <= '0;
         own_cost_ff    <= 8'd0;
         last_resel_ff  <= 32'd0;
         last_age_ff    <= 32'd0;
      end else begin
         if ((state_ff == ntps_pkg::ST_DECIDE) && is_tick && age_due) begin
            last_age_ff <= req_ff.now_seconds;
         end
         if (finish) begin
            parent_held_ff <= parent_held_in;
            parent_idx_ff  <= parent_idx_in;
            own_cost_ff    <= own_cost_in;
            last_resel_ff  <= last_resel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         par_addr_ff <= par_addr_in;
         par_slot_ff <= par_slot_in;
         par_chan_ff <= par_chan_in;
      end
   end

   // --------------------------------------------------------------------
   // Chain of entry cells; rotate toward the head, head re-enters at the tail
   // --------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ntps_pkg::entry_type shift_src;

      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign shift_src = tail_feed;
      end else begin : g_mid
         assign shift_src = cell_q[i+1];
      end

      assign cell_ctl[i].shift = (state_ff == ntps_pkg::ST_SCAN);
      assign cell_ctl[i].load  = finish && !is_tick && store_ok &&
                                 (target == IDX_W'(i));

      ntps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl[i]),
         .shift_in  (shift_src),
         .load_in   (new_entry),
         .entry_out (cell_q[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   a_parent_in_table: assert property (@(posedge clock) disable iff (reset)
      parent_held_ff |-> (int'(parent_idx_ff) < TABLE_ENTRIES))
      else $error("parent index outside the table");

   a_no_parent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.parent_valid) |->
         ((rsp_ff.parent_addr == 16'd0) && (rsp_ff.parent_slot == 8'd0) &&
          (rsp_ff.parent_channel == 8'd0)))
      else $error("parent fields not cleared without a parent");

   a_card_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ntps_pkg::STAT_TICK_DONE)) |->
         !rsp_ff.parent_changed)
      else $error("card transaction reported a parent change");

   a_commit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      finish |=> ((state_ff == ntps_pkg::ST_IDLE) && rsp_valid_ff))
      else $error("commit did not deliver a result");

   a_scan_runs_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ntps_pkg::ST_SCAN) && (idx_ff != LAST_IDX)) |=>
         (state_ff == ntps_pkg::ST_SCAN))
      else $error("rotation ended early");

endmodule

FILE: test/tb_neighbor_table_parent_select.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neighbor_table_parent_select: self-checking bench for the neighbor table
// Sends neighbor cards and time ticks through the request channel. A
// behavioral copy of the table computes the status and parent report of each
// transaction. The bench checks every result field by field and walks the
// registers through default, extreme and random settings.
// ----------------------------------------------------------------------------
module tb_neighbor_table_parent_select;

   localparam int TABLE_ENTRIES = ntps_pkg::TABLE_ENTRIES_DEF;
   // settle time after the last result, longer than one full transaction
   localparam int SETTLE_CYCLES = 2 * (TABLE_ENTRIES + 3);
   // about 1200 transactions, even under heavy stall and long sender gaps;
   // the limit leaves ample room
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_PERIODIC
   } flow_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ntps_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ntps_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [ntps_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ntps_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // register copies, reset values from the package
   logic signed [7:0] cfg_min_rssi = ntps_pkg::MIN_RSSI_RST;
   logic [7:0]        cfg_ttl = ntps_pkg::TIME_TO_LIVE_RST;
   logic [15:0]       cfg_age_period = ntps_pkg::AGE_PERIOD_RST;
   logic [15:0]       cfg_reselect_period = ntps_pkg::RESELECT_PERIOD_RST;
   logic [7:0]        cfg_etx_limit = ntps_pkg::ETX_LIMIT_RST;
   logic [7:0]        cfg_slot_low = ntps_pkg::SLOT_LOW_RST;
   logic [7:0]        cfg_slot_high = ntps_pkg::SLOT_HIGH_RST;

   // table state as the block should hold it
   ntps_pkg::entry_type neighbors [TABLE_ENTRIES];
   logic        parent_held = 1'b0;
   int          parent_idx = 0;
   logic [31:0] last_reselect = '0;
   logic [31:0] last_aging = '0;
   logic [7:0]  own_cost = '0;

   ntps_pkg::req_type radio_items [$];
   ntps_pkg::rsp_type due_reports [$];
   int          req_issued = 0;
   int          req_accepted = 0;
   int          failures = 0;
   int          cycle_count = 0;
   logic [31:0] uptime = '0;

   // sender and receiver pacing
   int           burst_left = 0;
   int           gap_left = 0;
   logic         flush_wait = 1'b0;
   flow_mode_type flow_mode = FLOW_FREE;
   int           flow_left = 0;

   // small address pool so cards hit existing entries and overflow the table
   logic [15:0] addr_pool [14] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234,
                                   16'h5A5A, 16'hA5A5, 16'h00FF, 16'hFF00, 16'h7FFF,
                                   16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3};

   neighbor_table_parent_select uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Advance the table by one transaction and return the report it produces.
   function automatic ntps_pkg::rsp_type advance_table(input ntps_pkg::req_type item);
      ntps_pkg::rsp_type rep;
      int          i;
      int          hit;
      int          best;
      logic        changed;
      logic        pick;
      logic [31:0] span;
      rep = '0;
      changed = 1'b0;
      hit = -1;
      best = -1;
      if (item.cmd == ntps_pkg::CMD_CARD) begin
         // length first, then signal strength, then slot, channel and etx
         if (item.payload_len != ntps_pkg::CARD_PAYLOAD) begin
            rep.status = ntps_pkg::STAT_BAD_LEN;
         end else if ($signed(item.rssi) < $signed(cfg_min_rssi)) begin
            rep.status = ntps_pkg::STAT_WEAK_RSSI;
         end else if (item.adv_slot < cfg_slot_low || item.adv_slot > cfg_slot_high ||
                      item.adv_channel < ntps_pkg::CHAN_LOW ||
                      item.adv_channel > ntps_pkg::CHAN_HIGH ||
                      item.adv_etx >= cfg_etx_limit) begin
            rep.status = ntps_pkg::STAT_INVALID;
         end else begin
            for (i = 0; i < TABLE_ENTRIES; i++)
               if (hit < 0 && neighbors[i].valid && neighbors[i].addr == item.sender_addr)
                  hit = i;
            for (i = 0; i < TABLE_ENTRIES; i++)
               if (hit < 0 && !neighbors[i].valid)
                  hit = i;
            if (hit < 0) begin
               rep.status = ntps_pkg::STAT_FULL;
            end else begin
               neighbors[hit].valid        = 1'b1;
               neighbors[hit].addr         = item.sender_addr;
               neighbors[hit].ttl          = cfg_ttl;
               neighbors[hit].rssi         = item.rssi;
               neighbors[hit].link_quality = item.link_quality;
               neighbors[hit].slot         = item.adv_slot;
               neighbors[hit].channel      = item.adv_channel;
               neighbors[hit].etx          = item.adv_etx;
               rep.status = ntps_pkg::STAT_STORED;
            end
         end
      end else begin
         // aging pass, differences wrap at 32 bits
         span = item.now_seconds - last_aging;
         if (span >= {16'h0000, cfg_age_period}) begin
            last_aging = item.now_seconds;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
               if (neighbors[i].valid) begin
                  if (neighbors[i].ttl != 8'd0)
                     neighbors[i].ttl = neighbors[i].ttl - 8'd1;
                  if (neighbors[i].ttl == 8'd0)
                     neighbors[i].valid = 1'b0;
               end
            end
         end
         // drop a parent whose entry expired
         if (parent_held && (parent_idx >= TABLE_ENTRIES || !neighbors[parent_idx].valid))
            parent_held = 1'b0;
         pick = 1'b1;
         if (parent_held) begin
            span = item.now_seconds - last_reselect;
            if (span < {16'h0000, cfg_reselect_period})
               pick = 1'b0;
            else
               last_reselect = item.now_seconds;
         end
         if (pick) begin
            // lowest etx, then higher rssi, then lower index
            for (i = 0; i < TABLE_ENTRIES; i++)
               if (neighbors[i].valid && (best < 0 || neighbors[i].etx < neighbors[best].etx ||
                   (neighbors[i].etx == neighbors[best].etx &&
                    $signed(neighbors[i].rssi) > $signed(neighbors[best].rssi))))
                  best = i;
            if (best >= 0) begin
               last_reselect = item.now_seconds;
               own_cost = neighbors[best].etx + 8'd1;
               if (!(parent_held && parent_idx == best)) begin
                  parent_idx = best;
                  parent_held = 1'b1;
                  changed = 1'b1;
               end
            end
         end
         rep.status = ntps_pkg::STAT_TICK_DONE;
      end
      if (parent_held && parent_idx < TABLE_ENTRIES) begin
         rep.parent_valid   = 1'b1;
         rep.parent_addr    = neighbors[parent_idx].addr;
         rep.parent_slot    = neighbors[parent_idx].slot;
         rep.parent_channel = neighbors[parent_idx].channel;
      end
      rep.own_etx = own_cost;
      rep.parent_changed = changed;
      return rep;
   endfunction

   function automatic ntps_pkg::req_type card_item(input logic [15:0] addr,
                                                   input logic signed [7:0] rssi,
                                                   input logic [7:0] slot,
                                                   input logic [7:0] chan,
                                                   input logic [7:0] etx,
                                                   input logic [7:0] len);
      ntps_pkg::req_type t;
      t.cmd          = ntps_pkg::CMD_CARD;
      t.sender_addr  = addr;
      t.rssi         = rssi;
      t.link_quality = 8'($urandom);
      t.adv_slot     = slot;
      t.adv_channel  = chan;
      t.adv_etx      = etx;
      t.payload_len  = len;
      t.now_seconds  = $urandom;
      return t;
   endfunction

   // card fields on a tick are noise the block must ignore
   function automatic ntps_pkg::req_type tick_item(input logic [31:0] now);
      ntps_pkg::req_type t;
      t = card_item(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      t.cmd = ntps_pkg::CMD_TICK;
      t.now_seconds = now;
      return t;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // Sampling side: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      ntps_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            due_reports.push_back(advance_table(req_data));
            req_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               $error("result transaction with none expected, status %0d", rsp_data.status);
               failures++;
            end else begin
               want = due_reports.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("parent_valid", want.parent_valid, rsp_data.parent_valid);
               check_field("parent_addr", want.parent_addr, rsp_data.parent_addr);
               check_field("parent_slot", want.parent_slot, rsp_data.parent_slot);
               check_field("parent_channel", want.parent_channel, rsp_data.parent_channel);
               check_field("own_etx", want.own_etx, rsp_data.own_etx);
               check_field("parent_changed", want.parent_changed, rsp_data.parent_changed);
            end
         end
      end
   end

   // Request driver: bursts and gaps; now and then hold until every result is back.
   always @(negedge clock) begin
      if (!reset && req_accepted == req_issued) begin
         if (flush_wait && due_reports.size() == 0)
            flush_wait = 1'b0;
         if (gap_left > 0 || flush_wait || radio_items.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_data <= radio_items.pop_front();
            req_valid <= 1'b1;
            req_issued++;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               flush_wait = ($urandom_range(0, 9) == 0);
            end
         end
      end
   end

   // Result stall: switch between free flow, light, heavy and periodic back-pressure.
   always @(negedge clock) begin
      if (flow_left == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 3));
         flow_left = $urandom_range(20, 300);
      end else begin
         flow_left--;
      end
      case (flow_mode)
         FLOW_FREE:  rsp_stall <= 1'b0;
         FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:    rsp_stall <= ((flow_left % 16) < 5);
      endcase
   end

   // Wait until every request is taken and every result is back, then let the block settle.
   task automatic settle_idle();
      while (radio_items.size() != 0 || req_accepted != req_issued || due_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input ntps_pkg::reg_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         ntps_pkg::REG_MIN_RSSI:        cfg_min_rssi = value[7:0];
         ntps_pkg::REG_TIME_TO_LIVE:    cfg_ttl = value[7:0];
         ntps_pkg::REG_AGE_PERIOD:      cfg_age_period = value;
         ntps_pkg::REG_RESELECT_PERIOD: cfg_reselect_period = value;
         ntps_pkg::REG_ETX_LIMIT:       cfg_etx_limit = value[7:0];
         ntps_pkg::REG_SLOT_LOW:        cfg_slot_low = value[7:0];
         default:                       cfg_slot_high = value[7:0];
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_settings(input logic signed [7:0] min_rssi, input logic [7:0] ttl,
                                 input logic [15:0] age, input logic [15:0] resel,
                                 input logic [7:0] etx_lim, input logic [7:0] slot_lo,
                                 input logic [7:0] slot_hi);
      settle_idle();
      write_reg(ntps_pkg::REG_MIN_RSSI, 16'(min_rssi));
      write_reg(ntps_pkg::REG_TIME_TO_LIVE, {8'h00, ttl});
      write_reg(ntps_pkg::REG_AGE_PERIOD, age);
      write_reg(ntps_pkg::REG_RESELECT_PERIOD, resel);
      write_reg(ntps_pkg::REG_ETX_LIMIT, {8'h00, etx_lim});
      write_reg(ntps_pkg::REG_SLOT_LOW, {8'h00, slot_lo});
      write_reg(ntps_pkg::REG_SLOT_HIGH, {8'h00, slot_hi});
      @(posedge clock);
   endtask

   // Mostly well-formed cards from the address pool, ticks on a moving uptime,
   // and a share of cards broken in one field.
   task automatic random_items(input int count);
      int          n;
      int          pick;
      int          lo;
      logic [31:0] span;
      logic [31:0] step;
      logic [15:0] addr;
      logic [7:0]  slot;
      logic [7:0]  etx;
      ntps_pkg::req_type t;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            span = (cfg_age_period == 16'd0) ? 32'd1 : {16'h0000, cfg_age_period};
            pick = $urandom_range(0, 99);
            if (pick < 45)
               step = $urandom_range(0, span / 2);
            else if (pick < 85)
               step = $urandom_range(span / 2, span * 2);
            else if (pick < 95)
               step = $urandom_range(0, 3);
            else
               step = $urandom;
            uptime = uptime + step;
            t = tick_item(uptime);
         end else begin
            addr = (pick < 85) ? addr_pool[$urandom_range(0, 13)] : 16'($urandom);
            lo = cfg_min_rssi;
            slot = (cfg_slot_low <= cfg_slot_high) ?
                   8'($urandom_range(cfg_slot_high, cfg_slot_low)) : 8'($urandom);
            etx = (cfg_etx_limit == 8'd0) ? 8'($urandom) :
                  ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) :
                  8'($urandom_range(0, cfg_etx_limit - 1));
            t = card_item(addr, 8'(lo + $urandom_range(0, 127 - lo)), slot,
                          8'($urandom_range(ntps_pkg::CHAN_HIGH, ntps_pkg::CHAN_LOW)),
                          etx, ntps_pkg::CARD_PAYLOAD);
            // break one field of some cards
            if ($urandom_range(0, 99) < 20) begin
               case ($urandom_range(0, 4))
                  0:       t.payload_len = 8'($urandom);
                  1:       t.rssi = 8'($urandom);
                  2:       t.adv_slot = 8'($urandom);
                  3:       t.adv_channel = 8'($urandom);
                  default: t.adv_etx = 8'($urandom);
               endcase
            end
         end
         radio_items.push_back(t);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("neighbor_table_parent_select regression: fail");
      $finish;
   end

   initial begin
      int round;
      for (round = 0; round < TABLE_ENTRIES; round++)
         neighbors[round] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed part at reset settings
      radio_items.push_back(tick_item(32'd0));  // empty table, no parent
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd10, 8'd15, 8'd3, 8'd0));
      // bad length beats weak rssi
      radio_items.push_back(card_item(16'h0101, -8'sd128, 8'd10, 8'd15, 8'd3, 8'd255));
      radio_items.push_back(card_item(16'h0101, -8'sd128, 8'd10, 8'd15, 8'd3,
                                      ntps_pkg::CARD_PAYLOAD));
      // weak rssi beats bad slot
      radio_items.push_back(card_item(16'h0101, -8'sd91, 8'd255, 8'd15, 8'd3,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd1, 8'd15, 8'd3,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd50, 8'd15, 8'd3,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd10, 8'd10, 8'd3,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd10, 8'd28, 8'd3,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd10, 8'd15, 8'd250,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'h0101, -8'sd40, 8'd10, 8'd15, 8'd255,
                                      ntps_pkg::CARD_PAYLOAD));
      // gateway at the lower edges, then the upper edges
      radio_items.push_back(card_item(16'h0000, -8'sd90, 8'd2, 8'd11, 8'd0,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(card_item(16'hFFFF, 8'sd127, 8'd49, 8'd27, 8'd249,
                                      ntps_pkg::CARD_PAYLOAD));
      // same etx as the gateway, stronger signal
      radio_items.push_back(card_item(16'h1234, -8'sd50, 8'd20, 8'd20, 8'd0,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(tick_item(32'd1));
      radio_items.push_back(card_item(16'h1234, -8'sd50, 8'd20, 8'd20, 8'd7,
                                      ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(tick_item(32'd61));  // age and reselect
      // fill the table, last one overflows
      for (round = 0; round < 8; round++)
         radio_items.push_back(card_item(16'h2000 + 16'(round), -8'sd60, 8'd30, 8'd16,
                                         8'(round + 1), ntps_pkg::CARD_PAYLOAD));
      radio_items.push_back(tick_item(32'hFFFF_FFF0));
      radio_items.push_back(tick_item(32'h0000_0020));  // difference across the wrap
      uptime = 32'h0000_0020;

      // lenient extremes
      apply_settings(-8'sd128, 8'd255, 16'd1, 16'd1, 8'd255, 8'd0, 8'd255);
      random_items(180);
      // zero time to live and zero periods: age and reselect on every tick
      apply_settings(-8'sd100, 8'd0, 16'd0, 16'd0, 8'd200, 8'd0, 8'd100);
      random_items(120);
      // strict extremes: empty slot window, nothing passes
      apply_settings(8'sd127, 8'd1, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255, 8'd0);
      random_items(50);
      for (round = 0; round < 4; round++) begin
         apply_settings(8'(-100 + $urandom_range(0, 70)), 8'($urandom_range(1, 20)),
                        16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
                        8'($urandom_range(10, 255)), 8'($urandom_range(0, 30)),
                        8'($urandom_range(20, 255)));
         if (round == 1)
            uptime = 32'hFFFF_F000;  // let the uptime cross the wrap
         random_items(180);
      end
      // back to reset values
      apply_settings(ntps_pkg::MIN_RSSI_RST, ntps_pkg::TIME_TO_LIVE_RST,
                     ntps_pkg::AGE_PERIOD_RST, ntps_pkg::RESELECT_PERIOD_RST,
                     ntps_pkg::ETX_LIMIT_RST, ntps_pkg::SLOT_LOW_RST,
                     ntps_pkg::SLOT_HIGH_RST);
      random_items(100);

      settle_idle();
      if (failures == 0 && due_reports.size() == 0) begin
         $display("neighbor_table_parent_select regression: pass");
      end else begin
         $display("neighbor_table_parent_select regression: fail");
      end
      $finish;
   end

endmodule
